@@ hdl/lift_axis_homing_supervisor_assert.svh @@
// Assertion macros for the lift axis homing supervisor.
// Included by the top level; needs no other file.
`ifndef LIFT_AXIS_HOMING_SUPERVISOR_ASSERT_SVH
`define LIFT_AXIS_HOMING_SUPERVISOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lahs_pkg.sv @@
// Shared types, codes and constants of the lift axis homing supervisor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lahs_pkg;

   // Field widths.
   localparam int ANGLE_BITS     = 24;
   localparam int DEG_PER_MM     = 18;
   localparam int HEIGHT_BITS    = 20;
   localparam int REQ_BITS       = 16;
   localparam int TOL_BITS       = 16;
   localparam int COUNT_BITS     = 8;
   localparam int MODE_BITS      = 3;
   localparam int FUNC_BITS      = 2;
   localparam int KIND_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Item codes.
   localparam logic [FUNC_BITS-1:0] FUNC_TICK   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_ZERO   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_HEIGHT = 2'd2;

   // Lift modes.
   localparam logic [MODE_BITS-1:0] MODE_UNZEROED = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_HOMING   = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_READY    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_MOVING   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_REACHED  = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_FAULT    = 3'd5;

   // Motor command kinds.
   localparam logic [KIND_BITS-1:0] CMD_NONE     = 2'd0;
   localparam logic [KIND_BITS-1:0] CMD_POSITION = 2'd1;
   localparam logic [KIND_BITS-1:0] CMD_SPEED    = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_HEIGHT     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REACHED_NEEDED = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOMING_LIMIT   = 2'd3;

   // Register reset values.
   localparam logic [TOL_BITS-1:0]   TOLERANCE_RESET      = 16'd32;
   localparam logic [REQ_BITS-1:0]   MAX_HEIGHT_RESET     = 16'd16000;
   localparam logic [COUNT_BITS-1:0] REACHED_NEEDED_RESET = 8'd20;
   localparam logic [COUNT_BITS-1:0] HOMING_LIMIT_RESET   = 8'd100;

   // Floor division of an angle difference by DEG_PER_MM. The difference is
   // biased by a multiple of the divisor so that it is never negative, then
   // divided exactly by a reciprocal multiply and the bias quotient removed.
   localparam int DIFF_BITS      = ANGLE_BITS + 1;
   localparam int DIV_Y_BITS     = ANGLE_BITS + 2;
   localparam int DIV_SHIFT_L    = $clog2(DEG_PER_MM);
   localparam int DIV_SHIFT      = DIV_Y_BITS + DIV_SHIFT_L;
   localparam int DIV_MULT_BITS  = DIV_Y_BITS + 1;
   localparam int DIV_PROD_BITS  = DIV_Y_BITS + DIV_MULT_BITS;
   localparam int DIV_Q_BITS     = DIV_PROD_BITS - DIV_SHIFT;
   localparam int DIV_H_BITS     = (DIV_Q_BITS + 1 > HEIGHT_BITS + 1) ?
                                   DIV_Q_BITS + 1 : HEIGHT_BITS + 1;
   localparam longint DIV_BIAS_K = ((longint'(1) << ANGLE_BITS) + DEG_PER_MM - 1)
                                   / DEG_PER_MM;
   localparam longint DIV_BIAS   = DIV_BIAS_K * DEG_PER_MM;
   localparam longint DIV_MULT   = ((longint'(1) << DIV_SHIFT) + DEG_PER_MM - 1)
                                   / DEG_PER_MM;

   // Width of the position command before saturation.
   localparam int DEG_BITS = $clog2(DEG_PER_MM + 1);
   localparam int CMD_W    = ((REQ_BITS + DEG_BITS > ANGLE_BITS) ?
                              REQ_BITS + DEG_BITS : ANGLE_BITS) + 2;

   typedef struct packed {
      logic [FUNC_BITS-1:0]         func;
      logic [REQ_BITS-1:0]          height_request;
      logic signed [ANGLE_BITS-1:0] motor_angle;
      logic                         motor_ok;
   } lahs_req_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]          mode;
      logic [KIND_BITS-1:0]          cmd_kind;
      logic signed [ANGLE_BITS-1:0]  cmd_angle;
      logic signed [HEIGHT_BITS-1:0] height_now;
      logic                          request_taken;
   } lahs_rsp_type;

   typedef struct packed {
      logic [TOL_BITS-1:0]   tolerance;
      logic [REQ_BITS-1:0]   max_height;
      logic [COUNT_BITS-1:0] reached_needed;
      logic [COUNT_BITS-1:0] homing_limit;
   } lahs_cfg_type;

endpackage

`default_nettype wire

@@ hdl/lahs_height_div.sv @@
// Converts a motor angle into a saturated lift height by floor division.
// Depends on lahs_pkg for widths and the reciprocal constants.
`default_nettype none

module lahs_height_div
   import lahs_pkg::*;
(
   input  wire logic signed [ANGLE_BITS-1:0]  motor_angle,
   input  wire logic signed [ANGLE_BITS-1:0]  zero_offset,
   output      logic signed [HEIGHT_BITS-1:0] height
);

   localparam logic [DIV_Y_BITS-1:0]    BIAS_Y = DIV_Y_BITS'(DIV_BIAS);
   localparam logic [DIV_MULT_BITS-1:0] MULT   = DIV_MULT_BITS'(DIV_MULT);
   localparam logic [DIV_H_BITS-1:0]    BIAS_Q = DIV_H_BITS'(DIV_BIAS_K);

   logic signed [DIFF_BITS-1:0] angle_diff;
   logic [DIV_Y_BITS-1:0]       biased;
   logic [DIV_PROD_BITS-1:0]    prod;
   logic [DIV_Q_BITS-1:0]       quot;
   logic [DIV_H_BITS-1:0]       wide_height;
   logic                        in_range;

   always_comb begin
      angle_diff  = DIFF_BITS'(motor_angle) - DIFF_BITS'(zero_offset);
      // The bias keeps the dividend positive; the sum wraps into range.
      biased      = DIV_Y_BITS'(angle_diff) + BIAS_Y;
      prod        = DIV_PROD_BITS'(biased) * DIV_PROD_BITS'(MULT);
      quot        = prod[DIV_PROD_BITS-1:DIV_SHIFT];
      wide_height = DIV_H_BITS'(quot) - BIAS_Q;
      in_range    = (&wide_height[DIV_H_BITS-1:HEIGHT_BITS-1]) ||
                    (~|wide_height[DIV_H_BITS-1:HEIGHT_BITS-1]);
      if (in_range) begin
         height = wide_height[HEIGHT_BITS-1:0];
      end else if (wide_height[DIV_H_BITS-1]) begin
         height = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
      end else begin
         height = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

@@ hdl/lahs_cfg_regs.sv @@
// Configuration registers of the lift axis homing supervisor.
// Depends on lahs_pkg for the register indexes, reset values and struct.
`default_nettype none

module lahs_cfg_regs
   import lahs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output      lahs_cfg_type              cfg
);

   lahs_cfg_type cfg_ff;
   lahs_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TOLERANCE: begin
               cfg_in.tolerance = csr_wdata[TOL_BITS-1:0];
            end
            CSR_MAX_HEIGHT: begin
               cfg_in.max_height = csr_wdata[REQ_BITS-1:0];
            end
            CSR_REACHED_NEEDED: begin
               cfg_in.reached_needed = csr_wdata[COUNT_BITS-1:0];
            end
            CSR_HOMING_LIMIT: begin
               cfg_in.homing_limit = csr_wdata[COUNT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance      <= TOLERANCE_RESET;
         cfg_ff.max_height     <= MAX_HEIGHT_RESET;
         cfg_ff.reached_needed <= REACHED_NEEDED_RESET;
         cfg_ff.homing_limit   <= HOMING_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/lahs_mode_ctrl.sv @@
// Mode sequencer of the lift axis homing supervisor: state registers and the
// per-item update. Depends on lahs_pkg and instantiates lahs_height_div.
`default_nettype none

module lahs_mode_ctrl
   import lahs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire lahs_req_type req,
   input  wire lahs_cfg_type cfg,
   output      lahs_rsp_type rsp_next
);

   localparam int BAND_W = HEIGHT_BITS + 1;

   logic [MODE_BITS-1:0]          mode_ff, mode_in;
   logic [COUNT_BITS-1:0]         in_band_count_ff, in_band_count_in;
   logic [COUNT_BITS-1:0]         homing_ticks_ff, homing_ticks_in;
   logic [REQ_BITS-1:0]           goal_height_ff, goal_height_in;
   logic signed [HEIGHT_BITS-1:0] current_height_ff, current_height_in;
   logic signed [ANGLE_BITS-1:0]  zero_offset_ff, zero_offset_in;

   logic signed [HEIGHT_BITS-1:0] height_calc;
   logic [BAND_W-1:0]             band_diff;
   logic [BAND_W-1:0]             band_dist;
   logic                          in_band;
   logic [COUNT_BITS-1:0]         ticks_inc;
   logic [COUNT_BITS-1:0]         count_next;
   logic [CMD_W-1:0]              cmd_wide;
   logic signed [ANGLE_BITS-1:0]  cmd_sat;
   logic                          cmd_in_range;
   logic                          angle_nonpos;
   logic [KIND_BITS-1:0]          kind;
   logic signed [ANGLE_BITS-1:0]  cmd;
   logic                          taken;

   lahs_height_div u_height_div (
      .motor_angle (req.motor_angle),
      .zero_offset (zero_offset_ff),
      .height      (height_calc)
   );

   // Position command for a height request, saturated to the angle range.
   always_comb begin
      cmd_wide = CMD_W'(req.height_request) * CMD_W'(DEG_PER_MM)
                 + CMD_W'(zero_offset_ff);
      cmd_in_range = (&cmd_wide[CMD_W-1:ANGLE_BITS-1]) ||
                     (~|cmd_wide[CMD_W-1:ANGLE_BITS-1]);
      if (cmd_in_range) begin
         cmd_sat = cmd_wide[ANGLE_BITS-1:0];
      end else if (cmd_wide[CMD_W-1]) begin
         cmd_sat = {1'b1, {(ANGLE_BITS-1){1'b0}}};
      end else begin
         cmd_sat = {1'b0, {(ANGLE_BITS-1){1'b1}}};
      end
   end

   // In-position test against the freshly computed height.
   always_comb begin
      band_diff = BAND_W'(height_calc) - BAND_W'(goal_height_ff);
      band_dist = band_diff[BAND_W-1] ? (~band_diff + BAND_W'(1)) : band_diff;
      in_band   = band_dist <= BAND_W'(cfg.tolerance);
      if (!in_band) begin
         count_next = '0;
      end else if (in_band_count_ff < cfg.reached_needed) begin
         count_next = in_band_count_ff + COUNT_BITS'(1);
      end else begin
         count_next = in_band_count_ff;
      end
      ticks_inc = (&homing_ticks_ff) ? homing_ticks_ff
                                     : homing_ticks_ff + COUNT_BITS'(1);
      angle_nonpos = req.motor_angle[ANGLE_BITS-1] || (req.motor_angle == '0);
   end

   always_comb begin
      mode_in           = mode_ff;
      in_band_count_in  = in_band_count_ff;
      homing_ticks_in   = homing_ticks_ff;
      goal_height_in    = goal_height_ff;
      current_height_in = current_height_ff;
      zero_offset_in    = zero_offset_ff;
      kind              = CMD_NONE;
      cmd               = '0;
      taken             = 1'b0;
      case (req.func)
         FUNC_TICK: begin
            if (mode_ff != MODE_UNZEROED && mode_ff != MODE_HOMING) begin
               current_height_in = height_calc;
            end
            case (mode_ff)
               MODE_HOMING: begin
                  if (angle_nonpos) begin
                     // The home switch position becomes the new zero.
                     zero_offset_in    = req.motor_angle;
                     kind              = CMD_POSITION;
                     cmd               = req.motor_angle;
                     goal_height_in    = '0;
                     current_height_in = '0;
                     homing_ticks_in   = '0;
                     mode_in           = MODE_READY;
                  end else begin
                     homing_ticks_in = ticks_inc;
                     if (ticks_inc >= cfg.homing_limit) begin
                        kind    = CMD_POSITION;
                        cmd     = req.motor_angle;
                        mode_in = MODE_FAULT;
                     end
                  end
               end
               MODE_MOVING: begin
                  in_band_count_in = count_next;
                  if (count_next >= cfg.reached_needed) begin
                     mode_in = MODE_REACHED;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
         FUNC_ZERO: begin
            if (mode_ff == MODE_UNZEROED) begin
               mode_in         = MODE_HOMING;
               homing_ticks_in = '0;
               kind            = CMD_SPEED;
            end
         end
         FUNC_HEIGHT: begin
            if ((mode_ff == MODE_READY || mode_ff == MODE_REACHED) &&
                req.height_request <= cfg.max_height) begin
               in_band_count_in = '0;
               kind             = CMD_POSITION;
               cmd              = cmd_sat;
               if (req.motor_ok) begin
                  goal_height_in = req.height_request;
                  mode_in        = MODE_MOVING;
                  taken          = 1'b1;
               end
            end
         end
         default: begin
            kind = CMD_NONE;
         end
      endcase

      rsp_next.mode          = mode_in;
      rsp_next.cmd_kind      = kind;
      rsp_next.cmd_angle     = cmd;
      rsp_next.height_now    = current_height_in;
      rsp_next.request_taken = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_UNZEROED;
         in_band_count_ff  <= '0;
         homing_ticks_ff   <= '0;
         goal_height_ff    <= '0;
         current_height_ff <= '0;
         zero_offset_ff    <= '0;
      end else if (fire) begin
         mode_ff           <= mode_in;
         in_band_count_ff  <= in_band_count_in;
         homing_ticks_ff   <= homing_ticks_in;
         goal_height_ff    <= goal_height_in;
         current_height_ff <= current_height_in;
         zero_offset_ff    <= zero_offset_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lift_axis_homing_supervisor.sv @@
// Lift axis homing and in-position supervisor, top level. Depends on lahs_pkg,
// lahs_cfg_regs, lahs_mode_ctrl and lift_axis_homing_supervisor_assert.svh.
//
// Each item on the req_ channel is a control tick, a zero command or a height
// request, and each one yields exactly one item on the rsp_ channel carrying
// the mode after the item, the motor command it causes and the current height.
// Both channels use valid and stall: an item moves on a rising edge with valid
// high and stall low. The csr_ port writes one of four registers whenever
// csr_we is high; it is meant to be used while no item is in flight.
//
// An item accepted into the input register is evaluated by the mode sequencer
// and the constant reciprocal divider, and its result is registered in the
// result register, which drives rsp_valid. One item per cycle is sustained
// while rsp_stall is low. The divider uses a single multiply.
// When rsp_stall is held, the result register keeps its item, the input
// register keeps one more item, and req_stall rises after that.
// A synchronous reset empties both registers, puts the lift in the unzeroed
// mode with zero offset and height, and reloads the register defaults.
`default_nettype none
`include "lift_axis_homing_supervisor_assert.svh"

module lift_axis_homing_supervisor
   import lahs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire lahs_req_type              req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      lahs_rsp_type              rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   lahs_req_type in_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   lahs_rsp_type rsp_data_ff;
   lahs_rsp_type rsp_next;
   lahs_cfg_type cfg;
   logic         fire;
   logic         accept;

   lahs_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lahs_mode_ctrl u_mode_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req      (in_data_ff),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   // The held item is evaluated whenever the result register is free or is
   // being emptied in the same cycle; the input register then takes a new
   // item at that same edge.
   always_comb begin
      fire         = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !fire;
      accept       = req_valid && !req_stall;
      in_valid_in  = accept || (in_valid_ff && !fire);
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A taken height request always commands a position and enters moving.
   `LAHS_ASSERT_NOW(a_taken_moving, clock, reset,
      rsp_valid_ff && rsp_data_ff.request_taken,
      rsp_data_ff.mode == MODE_MOVING && rsp_data_ff.cmd_kind == CMD_POSITION,
      "taken request without move")
   // The speed command is only issued on the way into homing.
   `LAHS_ASSERT_NOW(a_speed_homing, clock, reset,
      rsp_valid_ff && rsp_data_ff.cmd_kind == CMD_SPEED,
      rsp_data_ff.mode == MODE_HOMING && rsp_data_ff.cmd_angle == '0,
      "speed command outside homing")
   // An evaluated item always lands in the result register.
   `LAHS_ASSERT_NEXT(a_fire_result, clock, reset, fire, rsp_valid_ff, "evaluated item lost")
   // The input register only holds back while the result side is stalled.
   `LAHS_ASSERT_NOW(a_hold_reason, clock, reset, in_valid_ff && !fire,
      rsp_valid_ff && rsp_stall, "input held without stall")

endmodule

`default_nettype wire
